// File: sv/omniik_pkg.sv
// Types and constants shared by the omni wheel inverse kinematics block.
`default_nettype none

package omniik_pkg;

   localparam int VEL_W     = 16;
   localparam int SPEED_W   = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int N_WHEELS  = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_DIST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RADIUS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_EN    = 2'd2;

   localparam logic [CSR_W-1:0] RESET_WHEEL_DIST = 16'd256;
   localparam logic [CSR_W-1:0] RESET_INV_RADIUS = 16'd256;

   // 0.35355 in Q0.16.
   localparam logic [15:0] SCALE_K = 16'd23170;

   // Internal widths.
   localparam int SUM_W     = 42;                  // body term per wheel, Q.24
   localparam int LO_W      = SUM_W / 2;           // low half for the split product
   localparam int PL_W      = LO_W + CSR_W;        // low partial product
   localparam int PH_W      = SUM_W - LO_W + CSR_W + 1; // high partial product, signed
   localparam int W_W       = 58;                  // wheel speed, Q.32
   localparam int MAG_W     = SUM_W;
   localparam int QUO_W     = 15;
   localparam int DIV_STEPS = QUO_W;
   localparam int RND_SHIFT = 23;

   localparam int Q88_MAX  = 32767;
   localparam int Q88_MIN  = -32768;
   localparam int NORM_ONE = 16384;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] yaw_rate;
   } req_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] wheel_speed_a;
      logic signed [SPEED_W-1:0] wheel_speed_b;
      logic signed [SPEED_W-1:0] wheel_speed_c;
      logic signed [SPEED_W-1:0] wheel_speed_d;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/omni_wheel_inverse_kinematics.sv
// Pipelined inverse kinematics for a four-wheel omni base in X layout.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   omniik_pkg::req_type (vx, vy, yaw rate)
//   rsp_      out        rsp_valid/rsp_ready   omniik_pkg::rsp_type (wheel speeds a..d)
//   csr_      in         csr_wr_en             csr_index, csr_wdata
//
// One command is taken every cycle while the result side accepts or any stage is empty.
// Six arithmetic stages come first, then the fifteen-stage restoring divider for the
// normalised output, one quotient bit per stage, and then the output register.
// Reset clears every stage valid bit and loads the register defaults.
// A stage holds while the one after it is full and stalled; empty stages close up.
`default_nettype none

module omni_wheel_inverse_kinematics (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire omniik_pkg::req_type                  req_data,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      omniik_pkg::rsp_type                  rsp_data,
   input  wire logic                                 csr_wr_en,
   input  wire logic [omniik_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [omniik_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int NST   = 6 + omniik_pkg::DIV_STEPS + 1;
   localparam int NW    = omniik_pkg::N_WHEELS;
   localparam int SUM_W = omniik_pkg::SUM_W;
   localparam int MAG_W = omniik_pkg::MAG_W;
   localparam int QUO_W = omniik_pkg::QUO_W;
   localparam int W_W   = omniik_pkg::W_W;
   localparam int SP_W  = omniik_pkg::SPEED_W;
   localparam int LO_W  = omniik_pkg::LO_W;
   localparam int PL_W  = omniik_pkg::PL_W;
   localparam int PH_W  = omniik_pkg::PH_W;
   localparam int HI_W  = W_W - omniik_pkg::RND_SHIFT;
   localparam int DS    = omniik_pkg::DIV_STEPS;

   // Configuration registers.
   logic [omniik_pkg::CSR_W-1:0] wcd_ff;
   logic [omniik_pkg::CSR_W-1:0] irad_ff;
   logic                         norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wcd_ff  <= omniik_pkg::RESET_WHEEL_DIST;
         irad_ff <= omniik_pkg::RESET_INV_RADIUS;
         norm_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            omniik_pkg::CSR_WHEEL_DIST: begin
               wcd_ff <= csr_wdata;
            end
            omniik_pkg::CSR_INV_RADIUS: begin
               irad_ff <= csr_wdata;
            end
            omniik_pkg::CSR_NORM_EN: begin
               norm_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage valid bits and the ready chain.
   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;
   logic [NST:0]   adv;

   always_comb begin
      adv[NST] = rsp_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in = (adv[NST-1:0] & {v_ff[NST-2:0], req_valid}) | (~adv[NST-1:0] & v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = adv[0];

   // Stage 1: sum and difference of the velocities, yaw times wheel distance.
   logic signed [16:0] s1_dxy_ff, s1_sxy_ff;
   logic signed [32:0] s1_tp_ff;
   logic               s1_norm_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_dxy_ff  <= {req_data.vel_x[15], req_data.vel_x}
                       - {req_data.vel_y[15], req_data.vel_y};
         s1_sxy_ff  <= {req_data.vel_x[15], req_data.vel_x}
                       + {req_data.vel_y[15], req_data.vel_y};
         s1_tp_ff   <= $signed(req_data.yaw_rate) * $signed({1'b0, wcd_ff});
         s1_norm_ff <= norm_ff;
      end
   end

   // Stage 2: scale by K.
   logic signed [33:0] kd_in, ks_in;
   logic signed [31:0] s2_kd_ff, s2_ks_ff;
   logic signed [32:0] s2_tp_ff;
   logic               s2_norm_ff;

   always_comb begin
      kd_in = s1_dxy_ff * $signed({1'b0, omniik_pkg::SCALE_K});
      ks_in = s1_sxy_ff * $signed({1'b0, omniik_pkg::SCALE_K});
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_kd_ff   <= kd_in[31:0];
         s2_ks_ff   <= ks_in[31:0];
         s2_tp_ff   <= s1_tp_ff;
         s2_norm_ff <= s1_norm_ff;
      end
   end

   // Stage 3: per-wheel body term in Q.24.
   logic signed [SUM_W-1:0] t_in, kd_ext, ks_ext;
   logic signed [SUM_W-1:0] s3_s_ff [NW];
   logic                    s3_norm_ff;

   always_comb begin
      t_in   = {{(SUM_W - 41){s2_tp_ff[32]}}, s2_tp_ff, 8'd0};
      kd_ext = {{(SUM_W - 32){s2_kd_ff[31]}}, s2_kd_ff};
      ks_ext = {{(SUM_W - 32){s2_ks_ff[31]}}, s2_ks_ff};
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_s_ff[0] <= t_in - kd_ext;
         s3_s_ff[1] <= t_in - ks_ext;
         s3_s_ff[2] <= t_in + kd_ext;
         s3_s_ff[3] <= t_in + ks_ext;
         s3_norm_ff <= s2_norm_ff;
      end
   end

   // Stage 4: split product by the inverse radius, magnitudes for the divider.
   // The radius is a common factor, so the ratios are taken on the body terms.
   logic [PL_W-1:0]         pl_in   [NW];
   logic signed [PH_W-1:0]  ph_in   [NW];
   logic [PL_W-1:0]         s4_pl_ff  [NW];
   logic signed [PH_W-1:0]  s4_ph_ff  [NW];
   logic [MAG_W-1:0]        s4_mag_ff [NW];
   logic [NW-1:0]           s4_neg_ff;
   logic                    s4_norm_ff;

   always_comb begin
      for (int l = 0; l < NW; l++) begin
         pl_in[l] = s3_s_ff[l][LO_W-1:0] * irad_ff;
         ph_in[l] = $signed(s3_s_ff[l][SUM_W-1:LO_W]) * $signed({1'b0, irad_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int l = 0; l < NW; l++) begin
            s4_pl_ff[l]  <= pl_in[l];
            s4_ph_ff[l]  <= ph_in[l];
            s4_mag_ff[l] <= s3_s_ff[l][SUM_W-1] ? MAG_W'(-s3_s_ff[l]) : MAG_W'(s3_s_ff[l]);
            s4_neg_ff[l] <= s3_s_ff[l][SUM_W-1];
         end
         s4_norm_ff <= s3_norm_ff;
      end
   end

   // Stage 5: recombine the partial products, first level of the maximum.
   logic [PH_W+LO_W-1:0]   wsum_in [NW];
   logic signed [W_W-1:0]  s5_w_ff   [NW];
   logic [MAG_W-1:0]       s5_mag_ff [NW];
   logic [MAG_W-1:0]       s5_mx01_ff, s5_mx23_ff;
   logic [NW-1:0]          s5_neg_ff;
   logic                   s5_norm_ff;

   always_comb begin
      for (int l = 0; l < NW; l++) begin
         wsum_in[l] = {s4_ph_ff[l], {LO_W{1'b0}}}
                      + {{(PH_W + LO_W - PL_W){1'b0}}, s4_pl_ff[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int l = 0; l < NW; l++) begin
            s5_w_ff[l]   <= wsum_in[l][W_W-1:0];
            s5_mag_ff[l] <= s4_mag_ff[l];
         end
         s5_mx01_ff <= (s4_mag_ff[0] > s4_mag_ff[1]) ? s4_mag_ff[0] : s4_mag_ff[1];
         s5_mx23_ff <= (s4_mag_ff[2] > s4_mag_ff[3]) ? s4_mag_ff[2] : s4_mag_ff[3];
         s5_neg_ff  <= s4_neg_ff;
         s5_norm_ff <= s4_norm_ff;
      end
   end

   // Stage 6 loads element 0 of the divider arrays; element j holds step j.
   logic [MAG_W-1:0]      dv_rem_ff  [DS+1][NW];
   logic [QUO_W-1:0]      dv_quo_ff  [DS+1][NW];
   logic [SP_W-1:0]       dv_q88_ff  [DS+1][NW];
   logic [MAG_W-1:0]      dv_m_ff    [DS+1];
   logic                  dv_zero_ff [DS+1];
   logic [NW-1:0]         dv_neg_ff  [DS+1];
   logic                  dv_norm_ff [DS+1];

   logic signed [HI_W:0]  rnd_in [NW];
   logic signed [HI_W-1:0] q_in  [NW];
   logic [SP_W-1:0]       q88_in [NW];
   logic [MAG_W-1:0]      m_in;

   // Nearest, ties upward: floor((W + 2^23) / 2^24) = (floor(W / 2^23) + 1) >> 1.
   always_comb begin
      for (int l = 0; l < NW; l++) begin
         rnd_in[l] = $signed({s5_w_ff[l][W_W-1], s5_w_ff[l][W_W-1:omniik_pkg::RND_SHIFT]})
                     + $signed((HI_W + 1)'(1));
         q_in[l]   = rnd_in[l][HI_W:1];
         if (q_in[l] > $signed(HI_W'(omniik_pkg::Q88_MAX))) begin
            q88_in[l] = SP_W'(omniik_pkg::Q88_MAX);
         end else if (q_in[l] < $signed(HI_W'(omniik_pkg::Q88_MIN))) begin
            q88_in[l] = SP_W'(omniik_pkg::Q88_MIN);
         end else begin
            q88_in[l] = q_in[l][SP_W-1:0];
         end
      end
      m_in = (s5_mx01_ff > s5_mx23_ff) ? s5_mx01_ff : s5_mx23_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int l = 0; l < NW; l++) begin
            dv_rem_ff[0][l] <= s5_mag_ff[l];
            dv_quo_ff[0][l] <= '0;
            dv_q88_ff[0][l] <= q88_in[l];
         end
         dv_m_ff[0]    <= m_in;
         dv_zero_ff[0] <= (m_in == '0) || (irad_ff == '0);
         dv_neg_ff[0]  <= s5_neg_ff;
         dv_norm_ff[0] <= s5_norm_ff;
      end
   end

   // Restoring divider, one quotient bit per stage. The first step compares the
   // magnitude itself, since the ratio may reach one.
   for (genvar j = 1; j <= DS; j++) begin : g_div
      logic [MAG_W:0]   sh_in  [NW];
      logic [NW-1:0]    ge_in;
      logic [MAG_W:0]   sub_in [NW];

      always_comb begin
         for (int l = 0; l < NW; l++) begin
            sh_in[l]  = (j == 1) ? {1'b0, dv_rem_ff[j-1][l]} : {dv_rem_ff[j-1][l], 1'b0};
            ge_in[l]  = sh_in[l] >= {1'b0, dv_m_ff[j-1]};
            sub_in[l] = ge_in[l] ? sh_in[l] - {1'b0, dv_m_ff[j-1]} : sh_in[l];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[5+j]) begin
            for (int l = 0; l < NW; l++) begin
               dv_rem_ff[j][l] <= sub_in[l][MAG_W-1:0];
               dv_quo_ff[j][l] <= {dv_quo_ff[j-1][l][QUO_W-2:0], ge_in[l]};
               dv_q88_ff[j][l] <= dv_q88_ff[j-1][l];
            end
            dv_m_ff[j]    <= dv_m_ff[j-1];
            dv_zero_ff[j] <= dv_zero_ff[j-1];
            dv_neg_ff[j]  <= dv_neg_ff[j-1];
            dv_norm_ff[j] <= dv_norm_ff[j-1];
         end
      end
   end

   // Output stage: round half away from zero, restore the sign, select the format.
   logic [QUO_W-1:0] qr_in  [NW];
   logic [SP_W-1:0]  sel_in [NW];
   omniik_pkg::rsp_type rsp_ff;
   omniik_pkg::rsp_type rsp_in;
   logic                out_norm_ff;
   logic                out_zero_ff;

   always_comb begin
      for (int l = 0; l < NW; l++) begin
         qr_in[l] = dv_quo_ff[DS][l]
                    + QUO_W'({dv_rem_ff[DS][l], 1'b0} >= {1'b0, dv_m_ff[DS]});
         if (!dv_norm_ff[DS]) begin
            sel_in[l] = dv_q88_ff[DS][l];
         end else if (dv_zero_ff[DS]) begin
            sel_in[l] = '0;
         end else if (dv_neg_ff[DS][l]) begin
            sel_in[l] = SP_W'(-{1'b0, qr_in[l]});
         end else begin
            sel_in[l] = {1'b0, qr_in[l]};
         end
      end
      rsp_in.wheel_speed_a = sel_in[0];
      rsp_in.wheel_speed_b = sel_in[1];
      rsp_in.wheel_speed_c = sel_in[2];
      rsp_in.wheel_speed_d = sel_in[3];
   end

   always_ff @(posedge clock) begin
      if (adv[NST-1]) begin
         rsp_ff      <= rsp_in;
         out_norm_ff <= dv_norm_ff[DS];
         out_zero_ff <= dv_zero_ff[DS];
      end
   end

   assign rsp_valid = v_ff[NST-1];
   assign rsp_data  = rsp_ff;

   // A transfer on the request side always lands in the first stage.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_ff[0])
      else $error("accepted command did not enter the pipeline");

   // With the result side stalled, commands are taken exactly while a stage is empty.
   a_ready_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_ready |-> (req_ready == (v_ff != '1)))
      else $error("request ready does not follow pipeline occupancy");

   // Normalised speeds never exceed one in magnitude.
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_norm_ff) |->
         (rsp_data.wheel_speed_a <= omniik_pkg::NORM_ONE)
         && (rsp_data.wheel_speed_a >= -omniik_pkg::NORM_ONE)
         && (rsp_data.wheel_speed_b <= omniik_pkg::NORM_ONE)
         && (rsp_data.wheel_speed_b >= -omniik_pkg::NORM_ONE)
         && (rsp_data.wheel_speed_c <= omniik_pkg::NORM_ONE)
         && (rsp_data.wheel_speed_c >= -omniik_pkg::NORM_ONE)
         && (rsp_data.wheel_speed_d <= omniik_pkg::NORM_ONE)
         && (rsp_data.wheel_speed_d >= -omniik_pkg::NORM_ONE))
      else $error("normalised wheel speed out of range");

   // Unless all speeds are zero, the fastest wheel comes out at exactly one.
   a_norm_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_norm_ff && !out_zero_ff) |->
         (rsp_data.wheel_speed_a == omniik_pkg::NORM_ONE)
         || (rsp_data.wheel_speed_a == -omniik_pkg::NORM_ONE)
         || (rsp_data.wheel_speed_b == omniik_pkg::NORM_ONE)
         || (rsp_data.wheel_speed_b == -omniik_pkg::NORM_ONE)
         || (rsp_data.wheel_speed_c == omniik_pkg::NORM_ONE)
         || (rsp_data.wheel_speed_c == -omniik_pkg::NORM_ONE)
         || (rsp_data.wheel_speed_d == omniik_pkg::NORM_ONE)
         || (rsp_data.wheel_speed_d == -omniik_pkg::NORM_ONE))
      else $error("no normalised wheel speed reaches full scale");

endmodule

`default_nettype wire
